[hw/rtl/m68kieu_pkg.sv]
`default_nettype none
package m68kieu_pkg;

	typedef struct packed {
		logic [5:0]  operation;
		logic [15:0] opcode_word;
		logic [31:0] immediate_value;
	} op_item_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [4:0]  condition_codes;
		logic        divide_by_zero;
		logic        halted_flag;
	} res_item_t;

	typedef struct packed {
		logic load;
		logic read;
		logic exec;
		logic step;
		logic fin;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_iter;
		logic need_fin;
		logic count_last;
		logic slot_free;
	} ctrl_status_t;

	localparam logic [5:0] OP_NOP        = 6'd0;
	localparam logic [5:0] OP_MOVE       = 6'd1;
	localparam logic [5:0] OP_MOVE_ADDR  = 6'd2;
	localparam logic [5:0] OP_MOVE_QUICK = 6'd3;
	localparam logic [5:0] OP_ADD        = 6'd4;
	localparam logic [5:0] OP_ADDA       = 6'd5;
	localparam logic [5:0] OP_ADDI       = 6'd6;
	localparam logic [5:0] OP_ADDQ       = 6'd7;
	localparam logic [5:0] OP_ADDX       = 6'd8;
	localparam logic [5:0] OP_SUB        = 6'd9;
	localparam logic [5:0] OP_SUBA       = 6'd10;
	localparam logic [5:0] OP_SUBI       = 6'd11;
	localparam logic [5:0] OP_SUBQ       = 6'd12;
	localparam logic [5:0] OP_SUBX       = 6'd13;
	localparam logic [5:0] OP_CMP        = 6'd14;
	localparam logic [5:0] OP_CMPA       = 6'd15;
	localparam logic [5:0] OP_CMPI       = 6'd16;
	localparam logic [5:0] OP_AND        = 6'd17;
	localparam logic [5:0] OP_ANDI       = 6'd18;
	localparam logic [5:0] OP_OR         = 6'd19;
	localparam logic [5:0] OP_ORI        = 6'd20;
	localparam logic [5:0] OP_EOR        = 6'd21;
	localparam logic [5:0] OP_EORI       = 6'd22;
	localparam logic [5:0] OP_NOT        = 6'd23;
	localparam logic [5:0] OP_NEG        = 6'd24;
	localparam logic [5:0] OP_NEGX       = 6'd25;
	localparam logic [5:0] OP_CLR        = 6'd26;
	localparam logic [5:0] OP_TST        = 6'd27;
	localparam logic [5:0] OP_MULU       = 6'd28;
	localparam logic [5:0] OP_MULS       = 6'd29;
	localparam logic [5:0] OP_DIVU       = 6'd30;
	localparam logic [5:0] OP_DIVS       = 6'd31;
	localparam logic [5:0] OP_ASL        = 6'd32;
	localparam logic [5:0] OP_ASR        = 6'd33;
	localparam logic [5:0] OP_LSL        = 6'd34;
	localparam logic [5:0] OP_LSR        = 6'd35;
	localparam logic [5:0] OP_ROL        = 6'd36;
	localparam logic [5:0] OP_ROR        = 6'd37;
	localparam logic [5:0] OP_ROXL       = 6'd38;
	localparam logic [5:0] OP_ROXR       = 6'd39;

	localparam logic [1:0] SZ_BYTE     = 2'd0;
	localparam logic [1:0] SZ_WORD     = 2'd1;
	localparam logic [1:0] SZ_LONG     = 2'd2;
	localparam logic [1:0] SZ_WORD_ALT = 2'd3;

	localparam logic [5:0] DIV_STEPS = 6'd32;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		return (sz == SZ_BYTE) ? 32'h0000_00FF :
			((sz == SZ_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF);
	endfunction

	function automatic logic [31:0] size_msb(input logic [1:0] sz);
		return (sz == SZ_BYTE) ? 32'h0000_0080 :
			((sz == SZ_WORD) ? 32'h0000_8000 : 32'h8000_0000);
	endfunction

	function automatic logic [31:0] merge(input logic [31:0] old, input logic [31:0] v,
			input logic [1:0] sz);
		logic [31:0] m;
		m = size_mask(sz);
		return (old & ~m) | (v & m);
	endfunction

	function automatic logic [31:0] sext16(input logic [31:0] v);
		return {{16{v[15]}}, v[15:0]};
	endfunction

	function automatic logic [4:0] logic_flags(input logic [4:0] f, input logic [31:0] r,
			input logic [1:0] sz);
		return {f[4], |(r & size_msb(sz)), (r & size_mask(sz)) == 32'd0, 1'b0, 1'b0};
	endfunction

endpackage
`default_nettype wire

[hw/rtl/m68kieu_ctrl.sv]
`default_nettype none
module m68kieu_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        op_valid,
	output logic                       op_stall,
	input  m68kieu_pkg::ctrl_status_t  status,
	output m68kieu_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_ITER = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.need_iter) begin
					state_d = ST_ITER;
				end else if (status.need_fin) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ITER: begin
				cmd.step = 1'b1;
				if (status.count_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign op_stall = (state_q != ST_IDLE);

endmodule
`default_nettype wire

[hw/rtl/m68kieu_dp.sv]
`default_nettype none
module m68kieu_dp (
	input  wire                        clk,
	input  wire                        arst_n,
	input  m68kieu_pkg::ctrl_cmd_t     cmd,
	output m68kieu_pkg::ctrl_status_t  status,
	input  m68kieu_pkg::op_item_t      op_item,
	output logic                       res_valid,
	input  wire                        res_stall,
	output m68kieu_pkg::res_item_t     res_item
);

	logic [5:0]  op_q;
	logic [15:0] ow_q;
	logic [31:0] imm_q;

	logic [31:0] dmem [8];
	logic [7:0]  dvalid_q;
	logic [31:0] areg_q [8];
	logic [4:0]  flags_q;
	logic        halt_q;

	logic [31:0] a_q, b_q;
	logic [31:0] prod_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q, ud_q;
	logic        nn_q, nq_q;
	logic [31:0] sh_v_q;
	logic        sh_x_q, sh_out_q, sh_vf_q;
	logic [5:0]  cnt_q;

	logic [31:0] fin_res_q, fin_dval_q, fin_aval_q;
	logic [4:0]  fin_flags_q;
	logic        fin_dz_q, fin_halt_q, fin_dwe_q, fin_awe_q;
	logic [2:0]  fin_didx_q;

	logic        res_valid_q;
	m68kieu_pkg::res_item_t res_item_q;

	logic [2:0]  rd, rs;
	logic [1:0]  sz;
	logic [31:0] ar, imm_eff, quick32, src_a, m_sz, msb_sz;
	logic [3:0]  quick4;
	logic        xf, is_mul, is_div, is_shift, div_zero;

	always_comb begin
		rd       = ow_q[11:9];
		rs       = ow_q[2:0];
		sz       = (ow_q[7:6] == m68kieu_pkg::SZ_WORD_ALT) ? m68kieu_pkg::SZ_WORD : ow_q[7:6];
		ar       = areg_q[rd];
		imm_eff  = (sz == m68kieu_pkg::SZ_LONG) ? imm_q : {16'd0, imm_q[15:0]};
		quick4   = (rd == 3'd0) ? 4'd8 : {1'b0, rd};
		quick32  = {28'd0, quick4};
		src_a    = (sz == m68kieu_pkg::SZ_LONG) ? b_q : m68kieu_pkg::sext16(b_q);
		m_sz     = m68kieu_pkg::size_mask(sz);
		msb_sz   = m68kieu_pkg::size_msb(sz);
		xf       = flags_q[4];
		is_mul   = (op_q == m68kieu_pkg::OP_MULU) || (op_q == m68kieu_pkg::OP_MULS);
		is_div   = (op_q == m68kieu_pkg::OP_DIVU) || (op_q == m68kieu_pkg::OP_DIVS);
		is_shift = (op_q >= m68kieu_pkg::OP_ASL) && (op_q <= m68kieu_pkg::OP_ROXR);
		div_zero = (b_q[15:0] == 16'd0);
	end

	logic [31:0] add_d, add_s, add_r, add_m, add_msb;
	logic        add_x, add_sub, add_ext, add_keepx, add_c, add_v;
	logic [1:0]  add_sz;
	logic [32:0] sum33;
	logic [4:0]  add_flags;

	always_comb begin
		add_d     = a_q;
		add_s     = b_q;
		add_x     = 1'b0;
		add_sub   = 1'b0;
		add_ext   = 1'b0;
		add_keepx = 1'b0;
		add_sz    = sz;
		case (op_q)
			m68kieu_pkg::OP_ADDI: add_s = imm_eff;
			m68kieu_pkg::OP_ADDQ: begin
				add_d = b_q;
				add_s = quick32;
			end
			m68kieu_pkg::OP_ADDX: begin
				add_x   = xf;
				add_ext = 1'b1;
			end
			m68kieu_pkg::OP_SUB: add_sub = 1'b1;
			m68kieu_pkg::OP_SUBI: begin
				add_sub = 1'b1;
				add_s   = imm_eff;
			end
			m68kieu_pkg::OP_SUBQ: begin
				add_sub = 1'b1;
				add_d   = b_q;
				add_s   = quick32;
			end
			m68kieu_pkg::OP_SUBX: begin
				add_sub = 1'b1;
				add_x   = xf;
				add_ext = 1'b1;
			end
			m68kieu_pkg::OP_CMP: begin
				add_sub   = 1'b1;
				add_keepx = 1'b1;
			end
			m68kieu_pkg::OP_CMPA: begin
				add_sub   = 1'b1;
				add_keepx = 1'b1;
				add_d     = ar;
				add_s     = src_a;
				add_sz    = m68kieu_pkg::SZ_LONG;
			end
			m68kieu_pkg::OP_CMPI: begin
				add_sub   = 1'b1;
				add_keepx = 1'b1;
				add_s     = imm_eff;
			end
			m68kieu_pkg::OP_NEG: begin
				add_sub = 1'b1;
				add_d   = 32'd0;
				add_s   = a_q;
			end
			m68kieu_pkg::OP_NEGX: begin
				add_sub = 1'b1;
				add_d   = 32'd0;
				add_s   = a_q;
				add_x   = xf;
				add_ext = 1'b1;
			end
			default: begin
			end
		endcase
		add_m   = m68kieu_pkg::size_mask(add_sz);
		add_msb = m68kieu_pkg::size_msb(add_sz);
		if (add_sub) begin
			sum33 = {1'b0, add_d & add_m} - {1'b0, add_s & add_m} - {32'd0, add_x};
		end else begin
			sum33 = {1'b0, add_d & add_m} + {1'b0, add_s & add_m} + {32'd0, add_x};
		end
		add_r = sum33[31:0] & add_m;
		if (add_sub) begin
			add_c = sum33[32];
			add_v = |(((add_s ^ add_d) & (add_r ^ add_d)) & add_msb);
		end else begin
			add_c = |(sum33 & ~{1'b0, add_m});
			add_v = |(((add_s ^ add_r) & (add_d ^ add_r)) & add_msb);
		end
		add_flags = {add_keepx ? flags_q[4] : add_c, |(add_r & add_msb),
			add_ext ? (flags_q[2] & (add_r == 32'd0)) : (add_r == 32'd0), add_v, add_c};
	end

	logic [31:0] ex_res, ex_dval, ex_aval, lv, mv;
	logic [4:0]  ex_flags;
	logic        ex_dwe, ex_awe, ex_dz, ex_halt;
	logic [2:0]  ex_didx;

	always_comb begin
		ex_res   = 32'd0;
		ex_flags = flags_q;
		ex_dwe   = 1'b0;
		ex_didx  = rd;
		ex_dval  = 32'd0;
		ex_awe   = 1'b0;
		ex_aval  = 32'd0;
		ex_dz    = 1'b0;
		ex_halt  = halt_q;
		lv       = 32'd0;
		mv       = 32'd0;
		if (!halt_q) begin
			unique case (op_q) inside
				m68kieu_pkg::OP_MOVE: begin
					mv       = m68kieu_pkg::merge(a_q, b_q, sz);
					ex_dwe   = 1'b1;
					ex_dval  = mv;
					ex_flags = m68kieu_pkg::logic_flags(flags_q, b_q, sz);
					ex_res   = mv;
				end
				m68kieu_pkg::OP_MOVE_ADDR: begin
					ex_awe  = 1'b1;
					ex_aval = src_a;
					ex_res  = src_a;
				end
				m68kieu_pkg::OP_MOVE_QUICK: begin
					mv       = {{24{ow_q[7]}}, ow_q[7:0]};
					ex_dwe   = 1'b1;
					ex_dval  = mv;
					ex_flags = m68kieu_pkg::logic_flags(flags_q, mv, m68kieu_pkg::SZ_LONG);
					ex_res   = mv;
				end
				m68kieu_pkg::OP_ADD, m68kieu_pkg::OP_ADDI, m68kieu_pkg::OP_ADDX,
				m68kieu_pkg::OP_SUB, m68kieu_pkg::OP_SUBI, m68kieu_pkg::OP_SUBX,
				m68kieu_pkg::OP_NEG, m68kieu_pkg::OP_NEGX: begin
					mv       = m68kieu_pkg::merge(a_q, add_r, sz);
					ex_dwe   = 1'b1;
					ex_dval  = mv;
					ex_flags = add_flags;
					ex_res   = mv;
				end
				m68kieu_pkg::OP_ADDQ, m68kieu_pkg::OP_SUBQ: begin
					mv       = m68kieu_pkg::merge(b_q, add_r, sz);
					ex_dwe   = 1'b1;
					ex_didx  = rs;
					ex_dval  = mv;
					ex_flags = add_flags;
					ex_res   = mv;
				end
				m68kieu_pkg::OP_ADDA: begin
					ex_awe  = 1'b1;
					ex_aval = ar + src_a;
					ex_res  = ar + src_a;
				end
				m68kieu_pkg::OP_SUBA: begin
					ex_awe  = 1'b1;
					ex_aval = ar - src_a;
					ex_res  = ar - src_a;
				end
				m68kieu_pkg::OP_CMP, m68kieu_pkg::OP_CMPA, m68kieu_pkg::OP_CMPI: begin
					ex_res   = add_r;
					ex_flags = add_flags;
				end
				m68kieu_pkg::OP_AND, m68kieu_pkg::OP_ANDI, m68kieu_pkg::OP_OR,
				m68kieu_pkg::OP_ORI, m68kieu_pkg::OP_EOR, m68kieu_pkg::OP_EORI,
				m68kieu_pkg::OP_NOT, m68kieu_pkg::OP_CLR: begin
					case (op_q)
						m68kieu_pkg::OP_AND:  lv = a_q & b_q;
						m68kieu_pkg::OP_ANDI: lv = a_q & imm_eff;
						m68kieu_pkg::OP_OR:   lv = a_q | b_q;
						m68kieu_pkg::OP_ORI:  lv = a_q | imm_eff;
						m68kieu_pkg::OP_EOR:  lv = a_q ^ b_q;
						m68kieu_pkg::OP_EORI: lv = a_q ^ imm_eff;
						m68kieu_pkg::OP_NOT:  lv = ~a_q;
						default:              lv = 32'd0;
					endcase
					mv       = m68kieu_pkg::merge(a_q, lv, sz);
					ex_dwe   = 1'b1;
					ex_dval  = mv;
					ex_flags = m68kieu_pkg::logic_flags(flags_q, mv, sz);
					ex_res   = mv;
				end
				m68kieu_pkg::OP_TST: begin
					ex_flags = m68kieu_pkg::logic_flags(flags_q, a_q, sz);
					ex_res   = a_q & m_sz;
				end
				m68kieu_pkg::OP_DIVU, m68kieu_pkg::OP_DIVS: begin
					if (div_zero) begin
						ex_halt = 1'b1;
						ex_dz   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	logic [33:0] mul34;
	logic        mul_sgn;
	logic [31:0] un;
	logic [15:0] ud;
	logic        nn, nd;

	always_comb begin
		mul_sgn = (op_q == m68kieu_pkg::OP_MULS);
		mul34   = $signed({mul_sgn & b_q[15], b_q[15:0]}) *
			$signed({mul_sgn & a_q[15], a_q[15:0]});
		nn      = (op_q == m68kieu_pkg::OP_DIVS) && a_q[31];
		nd      = (op_q == m68kieu_pkg::OP_DIVS) && b_q[15];
		un      = nn ? (32'd0 - a_q) : a_q;
		ud      = nd ? (16'd0 - b_q[15:0]) : b_q[15:0];
	end

	logic [16:0] div_sh;
	logic [17:0] div_diff;

	always_comb begin
		div_sh   = {rem_q, quo_q[31]};
		div_diff = {1'b0, div_sh} - {2'b00, ud_q};
	end

	logic [31:0] sh_nv;
	logic        sh_nout, sh_nvf, sh_nx, sh_left, sh_before;

	always_comb begin
		sh_left   = (op_q == m68kieu_pkg::OP_ASL) || (op_q == m68kieu_pkg::OP_LSL) ||
			(op_q == m68kieu_pkg::OP_ROL) || (op_q == m68kieu_pkg::OP_ROXL);
		sh_before = |(sh_v_q & msb_sz);
		sh_nvf    = sh_vf_q;
		if (sh_left) begin
			sh_nout = sh_before;
			sh_nv   = (sh_v_q << 1) & m_sz;
			if (op_q == m68kieu_pkg::OP_ROL && sh_nout) begin
				sh_nv = sh_nv | 32'd1;
			end
			if (op_q == m68kieu_pkg::OP_ROXL && sh_x_q) begin
				sh_nv = sh_nv | 32'd1;
			end
			if (|(sh_nv & msb_sz) != sh_before) begin
				sh_nvf = 1'b1;
			end
		end else begin
			sh_nout = sh_v_q[0];
			sh_nv   = sh_v_q >> 1;
			if (op_q == m68kieu_pkg::OP_ASR) begin
				sh_nv = sh_nv | (sh_v_q & msb_sz);
			end
			if (op_q == m68kieu_pkg::OP_ROR && sh_nout) begin
				sh_nv = sh_nv | msb_sz;
			end
			if (op_q == m68kieu_pkg::OP_ROXR && sh_x_q) begin
				sh_nv = sh_nv | msb_sz;
			end
		end
		sh_nx = ((op_q == m68kieu_pkg::OP_ROL) || (op_q == m68kieu_pkg::OP_ROR)) ?
			sh_x_q : sh_nout;
	end

	logic [31:0] fn_res, fn_dval;
	logic [4:0]  fn_flags;
	logic        fn_dwe, div_ovf;
	logic [2:0]  fn_didx;
	logic [15:0] q16, r16;

	always_comb begin
		fn_res   = 32'd0;
		fn_dval  = 32'd0;
		fn_flags = flags_q;
		fn_dwe   = 1'b0;
		fn_didx  = rd;
		q16      = nq_q ? (16'd0 - quo_q[15:0]) : quo_q[15:0];
		r16      = nn_q ? (16'd0 - rem_q) : rem_q;
		if (op_q == m68kieu_pkg::OP_DIVU) begin
			div_ovf = |quo_q[31:16];
		end else begin
			div_ovf = quo_q > (nq_q ? 32'd32768 : 32'd32767);
		end
		if (is_mul) begin
			fn_dwe   = 1'b1;
			fn_dval  = prod_q;
			fn_flags = m68kieu_pkg::logic_flags(flags_q, prod_q, m68kieu_pkg::SZ_LONG);
			fn_res   = prod_q;
		end else if (is_div) begin
			if (div_ovf) begin
				fn_flags = {flags_q[4:2], 1'b1, 1'b0};
				fn_res   = a_q;
			end else begin
				fn_dwe   = 1'b1;
				fn_dval  = {r16, q16};
				fn_flags = m68kieu_pkg::logic_flags(flags_q, {16'd0, q16},
					m68kieu_pkg::SZ_WORD);
				fn_res   = {r16, q16};
			end
		end else begin
			fn_dwe   = 1'b1;
			fn_didx  = rs;
			fn_dval  = m68kieu_pkg::merge(b_q, sh_v_q, sz);
			fn_flags = {sh_x_q, |(sh_v_q & msb_sz), sh_v_q == 32'd0,
				(op_q == m68kieu_pkg::OP_ASL) && sh_vf_q, sh_out_q};
			fn_res   = fn_dval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_item.operation;
			ow_q  <= op_item.opcode_word;
			imm_q <= op_item.immediate_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			a_q <= dvalid_q[ow_q[11:9]] ? dmem[ow_q[11:9]] : 32'd0;
			b_q <= dvalid_q[ow_q[2:0]] ? dmem[ow_q[2:0]] : 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && fin_dwe_q) begin
			dmem[fin_didx_q] <= fin_dval_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			prod_q   <= mul34[31:0];
			nn_q     <= nn;
			nq_q     <= nn ^ nd;
			quo_q    <= un;
			rem_q    <= 16'd0;
			ud_q     <= ud;
			sh_v_q   <= b_q & m_sz;
			sh_x_q   <= xf;
			sh_out_q <= 1'b0;
			sh_vf_q  <= 1'b0;
			cnt_q    <= is_div ? m68kieu_pkg::DIV_STEPS : {2'b00, quick4};
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 6'd1;
			if (is_div) begin
				if (!div_diff[17]) begin
					rem_q <= div_diff[15:0];
				end else begin
					rem_q <= div_sh[15:0];
				end
				quo_q <= {quo_q[30:0], !div_diff[17]};
			end else begin
				sh_v_q   <= sh_nv;
				sh_x_q   <= sh_nx;
				sh_out_q <= sh_nout;
				sh_vf_q  <= sh_nvf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fin_res_q   <= ex_res;
			fin_flags_q <= ex_flags;
			fin_dz_q    <= ex_dz;
			fin_halt_q  <= ex_halt;
			fin_dwe_q   <= ex_dwe;
			fin_didx_q  <= ex_didx;
			fin_dval_q  <= ex_dval;
			fin_awe_q   <= ex_awe;
			fin_aval_q  <= ex_aval;
		end else if (cmd.fin) begin
			fin_res_q   <= fn_res;
			fin_flags_q <= fn_flags;
			fin_dz_q    <= 1'b0;
			fin_halt_q  <= halt_q;
			fin_dwe_q   <= fn_dwe;
			fin_didx_q  <= fn_didx;
			fin_dval_q  <= fn_dval;
			fin_awe_q   <= 1'b0;
			fin_aval_q  <= 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q    <= '0;
			areg_q      <= '{default: 32'd0};
			flags_q     <= 5'd0;
			halt_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (fin_dwe_q) begin
					dvalid_q[fin_didx_q] <= 1'b1;
				end
				if (fin_awe_q) begin
					areg_q[ow_q[11:9]] <= fin_aval_q;
				end
				flags_q     <= fin_flags_q;
				halt_q      <= fin_halt_q;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_item_q <= {fin_res_q, fin_flags_q, fin_dz_q, fin_halt_q};
		end
	end

	always_comb begin
		status.need_iter  = !halt_q && ((is_div && !div_zero) || is_shift);
		status.need_fin   = !halt_q && (is_mul || (is_div && !div_zero) || is_shift);
		status.count_last = (cnt_q == 6'd1);
		status.slot_free  = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule
`default_nettype wire

[hw/rtl/m68k_integer_execute_unit.sv]
`default_nettype none
// Executes one decoded 68000 register-to-register instruction per request and returns
// the result value, the flags, a divide-by-zero mark and the halt state.
// One request is in flight at a time, and a finished result waits in an output register
// while the next request is taken. Logic, move, add, subtract and compare requests pass
// through read, execute and done; multiplies add a finish step; shifts and rotates step
// the shifter one bit per cycle up to the shift count, and divides retire one quotient
// bit per cycle, each then finishing. A divide by zero skips these steps and halts the
// unit; later requests then return zero, leave all state unchanged and report the halt.
module m68k_integer_execute_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     op_valid,
	output logic                    op_stall,
	input  m68kieu_pkg::op_item_t   op_item,
	output logic                    res_valid,
	input  wire                     res_stall,
	output m68kieu_pkg::res_item_t  res_item
);

	m68kieu_pkg::ctrl_cmd_t    cmd;
	m68kieu_pkg::ctrl_status_t status;

	m68kieu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.status   (status),
		.cmd      (cmd)
	);

	m68kieu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.op_item   (op_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule
`default_nettype wire

[hw/rtl/m68kieu_chk.sv]
`default_nettype none
module m68kieu_chk (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     op_valid,
	input wire                     op_stall,
	input wire                     res_valid,
	input wire                     res_stall,
	input m68kieu_pkg::res_item_t  res_item
);

	logic seen_halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (res_valid && !res_stall && res_item.halted_flag) begin
			seen_halt_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("Stalled result changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("Second request taken while one is in flight.");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_halt_q |-> res_item.halted_flag)
		else $error("Halt state was lost.");

	a_dz_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.divide_by_zero |->
			res_item.halted_flag && (res_item.result_value == 32'd0))
		else $error("Zero divide did not halt with a zero result.");

endmodule

bind m68k_integer_execute_unit m68kieu_chk u_chk (.*);
`default_nettype wire
